@@ rtl/base62_integer_encoder_defines.svh @@
// Assertion macros shared by the base-62 encoder RTL.
`ifndef BASE62_INTEGER_ENCODER_DEFINES_SVH
`define BASE62_INTEGER_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define B62_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("base62 encoder check failed");
`define B62_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("base62 encoder check failed");
`else
`define B62_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define B62_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/b62_pkg.sv @@
// Types, constants and the digit alphabet for the base-62 encoder.
`default_nettype none

package b62_pkg;

   localparam int VALUE_W = 64;
   localparam int CAP_W   = 5;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd12;

   // Division by 62 walks the dividend 16 bits at a time.
   localparam int CHUNK_W     = 16;
   localparam int N_W         = DIGIT_W + CHUNK_W;
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_W     = 22;
   localparam int PROD_W      = N_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = 22'd2164802;   // floor(2^27 / 62)
   localparam logic [N_W-1:0]     RADIX = 22'd62;

   localparam int STEP_W = 3;

   // Datapath operations.
   localparam logic [2:0] OP_LOAD  = 3'd0;
   localparam logic [2:0] OP_DIV   = 3'd1;
   localparam logic [2:0] OP_STORE = 3'd2;
   localparam logic [2:0] OP_CHECK = 3'd3;
   localparam logic [2:0] OP_EMIT  = 3'd4;

   // Branch conditions.
   localparam logic [2:0] COND_NEVER   = 3'd0;
   localparam logic [2:0] COND_NOSTART = 3'd1;
   localparam logic [2:0] COND_MORE    = 3'd2;
   localparam logic [2:0] COND_FAIL    = 3'd3;
   localparam logic [2:0] COND_EMIT    = 3'd4;

   // Program steps.
   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DIV0  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_DIV1  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DIV2  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DIV3  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_STORE = 3'd5;
   localparam logic [STEP_W-1:0] STEP_CHECK = 3'd6;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd7;

   typedef struct packed {
      logic [2:0]        op;
      logic [2:0]        cond;
      logic [STEP_W-1:0] jump_to;
      logic [STEP_W-1:0] next_step;
   } ucode_type;

   typedef struct packed {
      logic more;
      logic fail;
      logic emit_more;
   } status_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      c = 7'd48;
      if (d < 6'd10) begin
         c = 7'd48 + CHAR_W'(d);
      end else if (d < 6'd36) begin
         c = 7'd97 + CHAR_W'(d - 6'd10);
      end else if (d < 6'd62) begin
         c = 7'd65 + CHAR_W'(d - 6'd36);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/base62_integer_encoder.sv @@
// Top level of the base-62 encoder: step counter, capacity register, datapath.
//
// A word is taken when start is high while busy is low; busy then stays high
// until the last character of that word has been issued. For a value of N
// base-62 digits (1 to 11 for a 64-bit value), each digit runs the division
// steps DIV0 to DIV3, since the single reciprocal multiplier retires 16
// dividend bits per cycle, and then the STORE step stores the digit; a fit
// check follows, then one character per cycle, most significant first. Each
// result word sits on the rsp_ ports for exactly one cycle with rsp_valid
// high and cannot be stalled; a misfit gives one word with rsp_ok low,
// rsp_digit_char zero and rsp_last high. The capacity register may be
// written only while busy is low and no result is pending.
`default_nettype none

`include "base62_integer_encoder_defines.svh"

module base62_integer_encoder #(
   parameter int MAX_DIGITS = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [b62_pkg::VALUE_W-1:0]   req_value,
   output logic                               rsp_valid,
   output logic [b62_pkg::CHAR_W-1:0]         rsp_digit_char,
   output logic                               rsp_last,
   output logic                               rsp_ok,
   input  wire logic                          csr_wr_en,
   input  wire logic [b62_pkg::CAP_W-1:0]     csr_wr_data
);

   logic [b62_pkg::STEP_W-1:0] step_ff, step_in;
   logic [b62_pkg::CAP_W-1:0]  cap_ff, cap_in;
   b62_pkg::ucode_type         ctrl;
   b62_pkg::status_type        status;
   logic                       take_jump;

   b62_ucode_rom u_rom (
      .step (step_ff),
      .ctrl (ctrl)
   );

   b62_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .value     (req_value),
      .capacity  (cap_ff),
      .status    (status),
      .out_valid (rsp_valid),
      .out_char  (rsp_digit_char),
      .out_last  (rsp_last),
      .out_ok    (rsp_ok)
   );

   always_comb begin
      case (ctrl.cond)
         b62_pkg::COND_NEVER:   take_jump = 1'b0;
         b62_pkg::COND_NOSTART: take_jump = !start;
         b62_pkg::COND_MORE:    take_jump = status.more;
         b62_pkg::COND_FAIL:    take_jump = status.fail;
         b62_pkg::COND_EMIT:    take_jump = status.emit_more;
         default:               take_jump = 1'b0;
      endcase
      step_in = take_jump ? ctrl.jump_to : ctrl.next_step;
      cap_in  = csr_wr_en ? csr_wr_data : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= b62_pkg::STEP_IDLE;
         cap_ff  <= b62_pkg::CAP_RESET;
      end else begin
         step_ff <= step_in;
         cap_ff  <= cap_in;
      end
   end

   assign busy = (step_ff != b62_pkg::STEP_IDLE);

   `B62_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy)
   `B62_ASSERT_IMP(a_rsp_in_run, clock, reset, rsp_valid, $past(busy))
   `B62_ASSERT_IMP(a_err_last, clock, reset, rsp_valid && !rsp_ok,
                   rsp_last && (rsp_digit_char == '0))
   `B62_ASSERT_NXT(a_last_ends, clock, reset, rsp_valid && rsp_last, !rsp_valid)

endmodule

`default_nettype wire

@@ rtl/b62_ucode_rom.sv @@
// Microprogram store: one control word per sequencer step.
`default_nettype none

module b62_ucode_rom (
   input  wire logic [b62_pkg::STEP_W-1:0] step,
   output b62_pkg::ucode_type              ctrl
);

   always_comb begin
      case (step)
         b62_pkg::STEP_IDLE: begin
            ctrl = '{b62_pkg::OP_LOAD, b62_pkg::COND_NOSTART,
                     b62_pkg::STEP_IDLE, b62_pkg::STEP_DIV0};
         end
         b62_pkg::STEP_DIV0: begin
            ctrl = '{b62_pkg::OP_DIV, b62_pkg::COND_NEVER,
                     b62_pkg::STEP_IDLE, b62_pkg::STEP_DIV1};
         end
         b62_pkg::STEP_DIV1: begin
            ctrl = '{b62_pkg::OP_DIV, b62_pkg::COND_NEVER,
                     b62_pkg::STEP_IDLE, b62_pkg::STEP_DIV2};
         end
         b62_pkg::STEP_DIV2: begin
            ctrl = '{b62_pkg::OP_DIV, b62_pkg::COND_NEVER,
                     b62_pkg::STEP_IDLE, b62_pkg::STEP_DIV3};
         end
         b62_pkg::STEP_DIV3: begin
            ctrl = '{b62_pkg::OP_DIV, b62_pkg::COND_NEVER,
                     b62_pkg::STEP_IDLE, b62_pkg::STEP_STORE};
         end
         b62_pkg::STEP_STORE: begin
            ctrl = '{b62_pkg::OP_STORE, b62_pkg::COND_MORE,
                     b62_pkg::STEP_DIV0, b62_pkg::STEP_CHECK};
         end
         b62_pkg::STEP_CHECK: begin
            ctrl = '{b62_pkg::OP_CHECK, b62_pkg::COND_FAIL,
                     b62_pkg::STEP_IDLE, b62_pkg::STEP_EMIT};
         end
         b62_pkg::STEP_EMIT: begin
            ctrl = '{b62_pkg::OP_EMIT, b62_pkg::COND_EMIT,
                     b62_pkg::STEP_EMIT, b62_pkg::STEP_IDLE};
         end
         default: begin
            ctrl = '{b62_pkg::OP_LOAD, b62_pkg::COND_NEVER,
                     b62_pkg::STEP_IDLE, b62_pkg::STEP_IDLE};
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/b62_datapath.sv @@
// Datapath: chunked division by 62, digit store and output word registers.
`default_nettype none

module b62_datapath #(
   parameter int MAX_DIGITS = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire b62_pkg::ucode_type            ctrl,
   input  wire logic [b62_pkg::VALUE_W-1:0]   value,
   input  wire logic [b62_pkg::CAP_W-1:0]     capacity,
   output b62_pkg::status_type                status,
   output logic                               out_valid,
   output logic [b62_pkg::CHAR_W-1:0]         out_char,
   output logic                               out_last,
   output logic                               out_ok
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CMP_W = ((CNT_W > b62_pkg::CAP_W) ? CNT_W : b62_pkg::CAP_W) + 1;

   logic [b62_pkg::VALUE_W-1:0] quo_ff, quo_in;
   logic [b62_pkg::DIGIT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [b62_pkg::DIGIT_W-1:0] store_ff [MAX_DIGITS];

   logic                        valid_ff, valid_in;
   logic [b62_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic                        last_ff, last_in;
   logic                        ok_ff, ok_in;

   logic [b62_pkg::N_W-1:0]     div_n;
   logic [b62_pkg::PROD_W-1:0]  div_prod;
   logic [b62_pkg::CHUNK_W-1:0] div_q_est, div_q;
   logic [b62_pkg::N_W-1:0]     div_r_est;
   logic [b62_pkg::DIGIT_W-1:0] div_r;
   logic                        store_wr;

   // Top chunk of the running quotient under the previous remainder. The
   // reciprocal estimate is at most one low, so one correction finishes it.
   always_comb begin
      div_n     = {rem_ff, quo_ff[b62_pkg::VALUE_W-1 -: b62_pkg::CHUNK_W]};
      div_prod  = b62_pkg::PROD_W'(div_n) * b62_pkg::PROD_W'(b62_pkg::RECIP);
      div_q_est = div_prod[b62_pkg::RECIP_SHIFT +: b62_pkg::CHUNK_W];
      div_r_est = div_n - (b62_pkg::N_W'({div_q_est, 6'b0})
                           - b62_pkg::N_W'({div_q_est, 1'b0}));
      if (div_r_est >= b62_pkg::RADIX) begin
         div_q = div_q_est + 1'b1;
         div_r = b62_pkg::DIGIT_W'(div_r_est - b62_pkg::RADIX);
      end else begin
         div_q = div_q_est;
         div_r = b62_pkg::DIGIT_W'(div_r_est);
      end
   end

   always_comb begin
      status.more      = (quo_ff != '0) &&
                         (({1'b0, cnt_ff} + 1'b1) < (CNT_W + 1)'(MAX_DIGITS));
      status.fail      = ((CMP_W'(cnt_ff) + 1'b1) > CMP_W'(capacity));
      status.emit_more = (idx_ff != '0);
   end

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      store_wr = 1'b0;
      valid_in = 1'b0;
      char_in  = char_ff;
      last_in  = last_ff;
      ok_in    = ok_ff;
      case (ctrl.op)
         b62_pkg::OP_LOAD: begin
            quo_in = value;
            rem_in = '0;
            cnt_in = '0;
         end
         b62_pkg::OP_DIV: begin
            quo_in = {quo_ff[b62_pkg::VALUE_W-b62_pkg::CHUNK_W-1:0], div_q};
            rem_in = div_r;
         end
         b62_pkg::OP_STORE: begin
            store_wr = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            rem_in   = '0;
         end
         b62_pkg::OP_CHECK: begin
            idx_in = IDX_W'(cnt_ff - 1'b1);
            if (status.fail) begin
               valid_in = 1'b1;
               char_in  = '0;
               last_in  = 1'b1;
               ok_in    = 1'b0;
            end
         end
         b62_pkg::OP_EMIT: begin
            valid_in = 1'b1;
            char_in  = b62_pkg::digit_to_char(store_ff[idx_ff]);
            last_in  = (idx_ff == '0);
            ok_in    = 1'b1;
            idx_in   = idx_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         quo_ff   <= quo_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
      ok_ff   <= ok_in;
      if (store_wr) begin
         store_ff[cnt_ff[IDX_W-1:0]] <= rem_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;
   assign out_ok    = ok_ff;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the base-62 integer encoder, with directed and random values.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [b62_pkg::CHAR_W-1:0] digit_char;
      logic                       last;
      logic                       ok;
   } char_word_type;

   localparam int NUM_DIGITS_MAX = 11;
   localparam int DRAIN_CYCLES   = 70;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CYCLE_LIMIT    = 300000;
   localparam int PHASE_ITEMS    = 20;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          start       = 1'b0;
   logic [b62_pkg::VALUE_W-1:0]   req_value   = '0;
   logic                          csr_wr_en   = 1'b0;
   logic [b62_pkg::CAP_W-1:0]     csr_wr_data = '0;
   logic                          busy;
   logic                          rsp_valid;
   logic [b62_pkg::CHAR_W-1:0]    rsp_digit_char;
   logic                          rsp_last;
   logic                          rsp_ok;

   char_word_type                 pending_chars[$];
   logic [b62_pkg::CAP_W-1:0]     capacity_model = b62_pkg::CAP_RESET;
   bit                            sender_idles   = 1'b1;
   int                            error_count    = 0;
   int                            cycle_count    = 0;

   base62_integer_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_ok         (rsp_ok),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [b62_pkg::CHAR_W-1:0] glyph(
      input logic [b62_pkg::DIGIT_W-1:0] d);
      if (d < 6'd10) begin
         return {1'b0, d} + 7'd48;
      end else if (d < 6'd36) begin
         return {1'b0, d} + 7'd87;
      end
      return {1'b0, d} + 7'd29;
   endfunction

   function automatic logic [b62_pkg::VALUE_W-1:0] pow62(input int n);
      logic [b62_pkg::VALUE_W-1:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd62;
      end
      return p;
   endfunction

   // Splits the value into base-62 digits, least significant first, then queues
   // the characters most significant first, or one error word if they do not fit.
   function automatic void predict_chars(input logic [b62_pkg::VALUE_W-1:0] v);
      logic [b62_pkg::DIGIT_W-1:0] digits [0:NUM_DIGITS_MAX-1];
      logic [b62_pkg::VALUE_W-1:0] q;
      int                          n;
      char_word_type               w;
      q = v;
      n = 0;
      do begin
         digits[n] = b62_pkg::DIGIT_W'(q % 64'd62);
         q = q / 64'd62;
         n++;
      end while (q != 0 && n < NUM_DIGITS_MAX);
      if (n + 1 > int'(capacity_model)) begin
         w.digit_char = '0;
         w.last       = 1'b1;
         w.ok         = 1'b0;
         pending_chars.push_back(w);
      end else begin
         for (int k = n - 1; k >= 0; k--) begin
            w.digit_char = glyph(digits[k]);
            w.last       = (k == 0);
            w.ok         = 1'b1;
            pending_chars.push_back(w);
         end
      end
   endfunction

   function automatic logic [b62_pkg::VALUE_W-1:0] random_value();
      logic [b62_pkg::VALUE_W-1:0] v;
      int                          n;
      n = $urandom_range(1, 10);
      case ($urandom_range(0, 7))
         0: v = pow62(n) - 64'd1;
         1: v = pow62(n);
         2: v = {64{1'b1}} >> $urandom_range(0, 63);
         default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      return v;
   endfunction

   task automatic report_error(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // Start stays high from one word to the next unless a gap is taken.
   task automatic send_value(input logic [b62_pkg::VALUE_W-1:0] v);
      if (sender_idles && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      predict_chars(v);
   endtask

   task automatic settle_encoder();
      start <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [b62_pkg::CAP_W-1:0] cap);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_model = cap;
      @(posedge clock);
   endtask

   // Alphabet boundaries and value extremes under the reset capacity.
   task automatic test_reset_capacity();
      send_value(64'd0);
      send_value(64'd9);
      send_value(64'd10);
      send_value(64'd35);
      send_value(64'd36);
      send_value(64'd61);
      send_value(64'd62);
      send_value(pow62(10));
      send_value({64{1'b1}});
      send_value({32{2'b01}});
   endtask

   // Capacities 2 and 11 are probed on both sides of the digit count they allow, the others on one side only.
   task automatic test_capacity_limits();
      settle_encoder();
      write_capacity(5'd0);
      send_value(64'd0);
      settle_encoder();
      write_capacity(5'd1);
      send_value(64'd61);
      settle_encoder();
      write_capacity(5'd2);
      send_value(64'd61);
      send_value(64'd62);
      settle_encoder();
      write_capacity(5'd11);
      send_value(pow62(10) - 64'd1);
      send_value(pow62(10));
      settle_encoder();
      write_capacity(5'd31);
      send_value({64{1'b1}});
   endtask

   task automatic test_random_traffic();
      logic [b62_pkg::CAP_W-1:0] cap;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: cap = 5'd16;
            1: cap = b62_pkg::CAP_W'($urandom_range(0, 31));
            2: cap = b62_pkg::CAP_W'($urandom_range(2, 12));
            default: cap = b62_pkg::CAP_RESET;
         endcase
         // The final phase runs back to back with no sender gaps.
         sender_idles = (phase != 3);
         settle_encoder();
         write_capacity(cap);
         repeat (PHASE_ITEMS) begin
            send_value(random_value());
            if (sender_idles && $urandom_range(0, 19) == 0) begin
               settle_encoder();
            end
         end
      end
   endtask

   always @(posedge clock) begin : check_words
      char_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_chars.size() == 0) begin
            report_error($sformatf("unexpected word: char=%0d last=%0b ok=%0b",
                                   rsp_digit_char, rsp_last, rsp_ok));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_digit_char !== want.digit_char || rsp_last !== want.last ||
                rsp_ok !== want.ok) begin
               report_error($sformatf(
                  "word differs: expected char=%0d last=%0b ok=%0b, got char=%0d last=%0b ok=%0b",
                  want.digit_char, want.last, want.ok, rsp_digit_char, rsp_last, rsp_ok));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_capacity();
      test_capacity_limits();
      test_random_traffic();
      settle_encoder();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ base62_integer_encoder.f @@
+incdir+rtl
rtl/b62_pkg.sv
rtl/b62_ucode_rom.sv
rtl/b62_datapath.sv
rtl/base62_integer_encoder.sv
tb/tb_top.sv
